// ----- src/u2a_pkg.sv -----
// Shared types and character constants for the UTF-8 to ASCII folder.
`timescale 1ns / 1ps

package u2a_pkg;

  // Job queue depth and pointer width
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Most characters one input beat can cause
  localparam int MAX_CHARS = 4;

  // ASCII codes used by the folding table
  localparam logic [6:0] CH_QMARK  = 7'h3F;
  localparam logic [6:0] CH_BAR    = 7'h7C;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_PLUS   = 7'h2B;
  localparam logic [6:0] CH_APOS   = 7'h27;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_STAR   = 7'h2A;
  localparam logic [6:0] CH_DOT    = 7'h2E;
  localparam logic [6:0] CH_GT     = 7'h3E;
  localparam logic [6:0] CH_LT     = 7'h3C;
  localparam logic [6:0] CH_CARET  = 7'h5E;
  localparam logic [6:0] CH_V      = 7'h76;
  localparam logic [6:0] CH_SPACE  = 7'h20;

  // One classified input beat: the characters it yields, in order
  typedef struct packed {
    logic [2:0]                     cnt;   // 1..4 characters
    logic [MAX_CHARS-1:0][6:0]      chars; // chars[0] goes out first
    logic                           eot;   // beat closed the text
  } job_t;

endpackage

// ----- src/utf8_to_ascii_folder_core.sv -----
// Top level of the UTF-8 to ASCII folder: classifier, job queue, emitter.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall   | in_byte[7:0], in_end_of_text
//   out_    | output    | out_valid / out_stall | out_char[6:0], out_item_last,
//           |           |                       | out_text_last
//
// One input byte per cycle is taken while the job queue has room; each byte
// yields 0 to 4 characters, and the emitter sends one character per cycle
// while the output is not stalled; a byte that yields none is not queued.
// The first character of a byte passes the job queue, the current-job register
// and the output register before it is presented.
// rst_n is synchronous, active low; it closes any open sequence and empties the
// queue and output register. out_stall holds the output register, then the
// emitter, then fills the queue; in_stall rises only when the queue is full.
`timescale 1ns / 1ps

module utf8_to_ascii_folder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char,
  output logic       out_item_last,
  output logic       out_text_last
);
  import u2a_pkg::*;

  logic q_full, q_push, q_pop, q_not_empty;
  job_t push_job, pop_job;

  u2a_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  u2a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_job   (pop_job),
    .not_empty (q_not_empty)
  );

  u2a_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_item_last (out_item_last),
    .out_text_last (out_text_last)
  );

endmodule

// ----- src/u2a_front.sv -----
// Front end: UTF-8 sequence tracking and classification of each byte into a job.
`timescale 1ns / 1ps

module u2a_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_text,
  input  logic          q_full,
  output logic          q_push,
  output u2a_pkg::job_t q_job
);
  import u2a_pkg::*;

  // Folded string of a complete code point
  typedef struct packed {
    logic [1:0]      len;
    logic [2:0][6:0] s;
  } fold_t;

  function automatic fold_t fold_code(input logic [20:0] cp);
    fold_t f;
    f.len = 2'd1;
    f.s   = {CH_QMARK, CH_QMARK, CH_QMARK};
    if (cp[20:7] == 14'h004A) begin
      // box-drawing block U+2500..U+257F
      case (cp[6:0]) inside
        7'h02, 7'h03, 7'h06, 7'h07, 7'h0A, 7'h0B, 7'h51: f.s[0] = CH_BAR;
        7'h00, 7'h01, 7'h04, 7'h05, 7'h08, 7'h09, 7'h50: f.s[0] = CH_DASH;
        default:                                         f.s[0] = CH_PLUS;
      endcase
    end else begin
      unique case (cp) inside
        21'h02012, 21'h02013, 21'h02014, 21'h02015: f.s[0] = CH_DASH;
        21'h02018, 21'h02019:                       f.s[0] = CH_APOS;
        21'h0201C, 21'h0201D:                       f.s[0] = CH_DQUOTE;
        21'h02022, 21'h000B7:                       f.s[0] = CH_STAR;
        21'h02026: begin
          f.len = 2'd3;
          f.s   = {CH_DOT, CH_DOT, CH_DOT};
        end
        21'h02192: begin
          f.len  = 2'd2;
          f.s[0] = CH_DASH;
          f.s[1] = CH_GT;
        end
        21'h02190: begin
          f.len  = 2'd2;
          f.s[0] = CH_LT;
          f.s[1] = CH_DASH;
        end
        21'h02191:                                  f.s[0] = CH_CARET;
        21'h02193:                                  f.s[0] = CH_V;
        21'h000A0:                                  f.s[0] = CH_SPACE;
        default:                                    f.s[0] = CH_QMARK;
      endcase
    end
    return f;
  endfunction

  // Sequence state
  logic [1:0]  exp_r, exp_nxt;
  logic [1:0]  taken_r, taken_nxt;
  logic [20:0] acc_r, acc_nxt;

  logic        accept;
  logic        is_cont, is_ascii, lead2, lead3, lead4, seq_open;
  logic [1:0]  taken_inc;
  logic [20:0] acc_shift;
  fold_t       fold;
  logic [1:0]  qcnt;     // leading '?' count
  logic [1:0]  slen;     // length of the string after them
  logic [3:0][6:0] str;
  logic [1:0]  sel;

  assign accept   = in_valid && !in_stall;
  assign in_stall = q_full;

  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign is_ascii  = !in_byte[7];
  assign lead2     = (in_byte[7:5] == 3'b110);
  assign lead3     = (in_byte[7:4] == 4'b1110);
  assign lead4     = (in_byte[7:3] == 5'b11110);
  assign seq_open  = (exp_r != 2'd0);
  assign taken_inc = taken_r + 2'd1;
  assign acc_shift = {acc_r[14:0], in_byte[5:0]};
  assign fold      = fold_code(acc_shift);

  // Classify the byte against the open sequence
  always_comb begin
    exp_nxt   = exp_r;
    taken_nxt = taken_r;
    acc_nxt   = acc_r;
    qcnt      = 2'd0;
    slen      = 2'd0;
    str       = {CH_QMARK, CH_QMARK, CH_QMARK, CH_QMARK};
    if (seq_open && is_cont) begin
      if (taken_inc == exp_r) begin
        // sequence complete: fold it
        slen      = fold.len;
        str[2:0]  = fold.s;
        exp_nxt   = 2'd0;
        taken_nxt = 2'd0;
        acc_nxt   = '0;
      end else if (in_end_of_text) begin
        // truncated at end of text
        qcnt      = taken_inc + 2'd1;
        exp_nxt   = 2'd0;
        taken_nxt = 2'd0;
        acc_nxt   = '0;
      end else begin
        taken_nxt = taken_inc;
        acc_nxt   = acc_shift;
      end
    end else begin
      // broken sequence flushes first, then the byte is taken afresh
      qcnt      = seq_open ? (taken_r + 2'd1) : 2'd0;
      exp_nxt   = 2'd0;
      taken_nxt = 2'd0;
      acc_nxt   = '0;
      if (is_ascii) begin
        slen   = 2'd1;
        str[0] = in_byte[6:0];
      end else if (lead2 || lead3 || lead4) begin
        if (in_end_of_text) begin
          slen = 2'd1;
        end else begin
          exp_nxt = lead2 ? 2'd1 : (lead3 ? 2'd2 : 2'd3);
          acc_nxt = lead2 ? {16'd0, in_byte[4:0]}
                  : (lead3 ? {17'd0, in_byte[3:0]} : {18'd0, in_byte[2:0]});
        end
      end else begin
        slen = 2'd1;
      end
    end
  end

  // Pack '?' prefix and string into the job
  always_comb begin
    q_job.cnt = {1'b0, qcnt} + {1'b0, slen};
    q_job.eot = in_end_of_text;
    for (int k = 0; k < MAX_CHARS; k++) begin
      sel = 2'(k) - qcnt;
      q_job.chars[k] = (2'(k) < qcnt) ? CH_QMARK : str[sel];
    end
  end

  assign q_push = accept && (q_job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= 2'd0;
      taken_r <= 2'd0;
      acc_r   <= '0;
    end else if (accept) begin
      exp_r   <= exp_nxt;
      taken_r <= taken_nxt;
      acc_r   <= acc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r == 2'd0) |-> (taken_r == 2'd0 && acc_r == 21'd0))
    else $error("closed sequence left residue");
  a_taken_below: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != 2'd0) |-> (taken_r < exp_r))
    else $error("continuation count reached expected count");
  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full && q_job.cnt <= 3'(MAX_CHARS)))
    else $error("job pushed into full queue or too long");
`endif

endmodule

// ----- src/u2a_queue.sv -----
// Short job queue between the classifier and the character emitter.
`timescale 1ns / 1ps

module u2a_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u2a_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output u2a_pkg::job_t pop_job,
  output logic          not_empty
);
  import u2a_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_job   = mem[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

endmodule

// ----- src/u2a_back.sv -----
// Back end: walks each job; one char beat per cycle unless stalled.
`timescale 1ns / 1ps

module u2a_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  u2a_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [6:0]    out_char,
  output logic          out_item_last,
  output logic          out_text_last
);
  import u2a_pkg::*;

  job_t       cur_r;
  logic       cur_vld_r;
  logic [1:0] idx_r;

  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_item_last_r, out_text_last_r;

  logic out_ld, emit, last, cur_done;

  assign out_ld   = !out_valid_r || !out_stall;
  assign emit     = cur_vld_r && out_ld;
  assign last     = ({1'b0, idx_r} + 3'd1) == cur_r.cnt;
  assign cur_done = emit && last;
  assign q_pop    = q_not_empty && (!cur_vld_r || cur_done);

  // current job and character index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (q_pop) begin
      cur_vld_r <= 1'b1;
      idx_r     <= 2'd0;
    end else begin
      if (cur_done) cur_vld_r <= 1'b0;
      if (emit) idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_job;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r      <= cur_r.chars[idx_r];
      out_item_last_r <= last;
      out_text_last_r <= last && cur_r.eot;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_item_last = out_item_last_r;
  assign out_text_last = out_text_last_r;

`ifndef SYNTHESIS
  a_text_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_text_last_r |-> out_item_last_r)
    else $error("text_last without item_last");
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (cur_r.cnt != 3'd0 && ({1'b0, idx_r} < cur_r.cnt)))
    else $error("character index beyond job length");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && cur_vld_r |-> cur_done)
    else $error("job loaded over unfinished job");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the UTF-8 to ASCII folder core.
`timescale 1ns / 1ps

module tb_top;
  import u2a_pkg::*;

  localparam int QUIET_LIMIT   = 4000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES  = 10;    // tail after the last character
  localparam int NUM_FOLD_CPS  = 35;
  localparam int HOLD_CYCLES   = 80;

  // One character beat at the output
  typedef struct packed {
    logic [6:0] ch;
    logic       item_last;
    logic       text_last;
  } ascii_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_char;
  logic       out_item_last;
  logic       out_text_last;

  // Predictor state: the open UTF-8 sequence
  logic [1:0]  seq_need = 2'd0;
  logic [1:0]  seq_got = 2'd0;
  logic [20:0] seq_code = 21'd0;
  logic [6:0]  fold_chars[$];
  ascii_beat_t ascii_due_q[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int bytes_sent = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  utf8_to_ascii_folder_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .out_item_last  (out_item_last),
    .out_text_last  (out_text_last)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Folding predictor
  // ---------------------------------------------------------------------------
  function automatic void put_ascii(logic [6:0] c);
    if (fold_chars.size() < MAX_CHARS) fold_chars = {fold_chars, c};
  endfunction

  function automatic void close_open_seq();
    seq_need = 2'd0;
    seq_got  = 2'd0;
    seq_code = 21'd0;
  endfunction

  // '?' for the lead plus one per continuation already taken
  function automatic void flush_open_seq();
    int k;
    put_ascii(CH_QMARK);
    for (k = 0; k < seq_got; k++) put_ascii(CH_QMARK);
    close_open_seq();
  endfunction

  function automatic void start_byte(logic [7:0] b);
    if (b[7] == 1'b0) begin
      put_ascii(b[6:0]);
    end else if (b[7:5] == 3'b110) begin
      seq_need = 2'd1;
      seq_got  = 2'd0;
      seq_code = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      seq_need = 2'd2;
      seq_got  = 2'd0;
      seq_code = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      seq_need = 2'd3;
      seq_got  = 2'd0;
      seq_code = {18'd0, b[2:0]};
    end else begin
      // stray continuation or 0xF8..0xFF
      put_ascii(CH_QMARK);
    end
  endfunction

  function automatic void fold_code_point(logic [20:0] cp);
    if (cp >= 21'h2500 && cp <= 21'h257F) begin
      case (cp)
        21'h2502, 21'h2503, 21'h2506, 21'h2507,
        21'h250A, 21'h250B, 21'h2551: put_ascii(CH_BAR);
        21'h2500, 21'h2501, 21'h2504, 21'h2505,
        21'h2508, 21'h2509, 21'h2550: put_ascii(CH_DASH);
        default: put_ascii(CH_PLUS);
      endcase
    end else begin
      case (cp)
        21'h2012, 21'h2013, 21'h2014, 21'h2015: put_ascii(CH_DASH);
        21'h2018, 21'h2019: put_ascii(CH_APOS);
        21'h201C, 21'h201D: put_ascii(CH_DQUOTE);
        21'h2022, 21'h00B7: put_ascii(CH_STAR);
        21'h2026: begin
          put_ascii(CH_DOT);
          put_ascii(CH_DOT);
          put_ascii(CH_DOT);
        end
        21'h2192: begin
          put_ascii(CH_DASH);
          put_ascii(CH_GT);
        end
        21'h2190: begin
          put_ascii(CH_LT);
          put_ascii(CH_DASH);
        end
        21'h2191: put_ascii(CH_CARET);
        21'h2193: put_ascii(CH_V);
        21'h00A0: put_ascii(CH_SPACE);
        default: put_ascii(CH_QMARK);
      endcase
    end
  endfunction

  // Advance the predictor by one accepted byte and queue its characters
  function automatic void fold_byte(logic [7:0] b, logic eot);
    ascii_beat_t beat;
    int k;
    fold_chars.delete();
    if (seq_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        seq_code = {seq_code[14:0], b[5:0]};
        seq_got  = seq_got + 2'd1;
        if (seq_got >= seq_need) begin
          fold_code_point(seq_code);
          close_open_seq();
        end
      end else begin
        // broken sequence, then the byte starts over
        flush_open_seq();
        start_byte(b);
      end
    end else begin
      start_byte(b);
    end
    // truncated text
    if (eot && seq_need != 2'd0) flush_open_seq();

    for (k = 0; k < fold_chars.size(); k++) begin
      beat.ch        = fold_chars[k];
      beat.item_last = (k == fold_chars.size() - 1);
      beat.text_last = beat.item_last && eot;
      ascii_due_q    = {ascii_due_q, beat};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Byte idx of the len-byte encoding of cp (overlong forms allowed)
  function automatic logic [7:0] enc_byte(logic [20:0] cp, int len, int idx);
    logic [20:0] p;
    p = cp >> (6 * (len - 1 - idx));
    if (idx != 0) return {2'b10, p[5:0]};
    case (len)
      2:       return {3'b110, p[4:0]};
      3:       return {4'b1110, p[3:0]};
      default: return {5'b11110, p[2:0]};
    endcase
  endfunction

  // Code points of the folding table and their close neighbors
  function automatic logic [20:0] fold_cp_at(int i);
    case (i)
      0:  return 21'h2502;  1:  return 21'h2503;  2:  return 21'h2506;
      3:  return 21'h2507;  4:  return 21'h250A;  5:  return 21'h250B;
      6:  return 21'h2551;  7:  return 21'h2500;  8:  return 21'h2501;
      9:  return 21'h2504;  10: return 21'h2505;  11: return 21'h2508;
      12: return 21'h2509;  13: return 21'h2550;  14: return 21'h257F;
      15: return 21'h2510;  16: return 21'h24FF;  17: return 21'h2580;
      18: return 21'h2011;  19: return 21'h2012;  20: return 21'h2015;
      21: return 21'h2016;  22: return 21'h2018;  23: return 21'h2019;
      24: return 21'h201C;  25: return 21'h201D;  26: return 21'h2022;
      27: return 21'h00B7;  28: return 21'h2026;  29: return 21'h2192;
      30: return 21'h2190;  31: return 21'h2191;  32: return 21'h2193;
      33: return 21'h00A0;  default: return 21'h2194;
    endcase
  endfunction

  // Offer one byte, wait for the beat, then predict
  task automatic send_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    fold_byte(b, eot);
    bytes_sent++;
  endtask

  // First n bytes of a len-byte sequence; eot goes on the last one sent
  task automatic send_cp(input logic [20:0] cp, input int len, input int n,
                         input logic eot);
    int i;
    for (i = 0; i < n; i++) send_byte(enc_byte(cp, len, i), eot && (i == n - 1));
  endtask

  task automatic drain_text_out();
    in_valid <= 1'b0;
    while (ascii_due_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [8:0] beats[$] = '{
      9'h000, 9'h07F,                   // ASCII extremes
      9'h080, 9'h0F8, 9'h0FF,           // stray bytes
      9'h0E2, 9'h094, 9'h082,           // box vertical
      9'h0E2, 9'h080, 9'h0A6,           // ellipsis
      9'h0C2, 9'h0A0,                   // nbsp
      9'h0F0, 9'h09F, 9'h098, 9'h041,   // broken after two continuations
      9'h0F0, 9'h090, 9'h080, 9'h080,   // 4-byte form, unlisted
      9'h0C3, 9'h0E2, 9'h180,           // broken, then truncated by end of text
      9'h1C2                            // lone lead at end of text
    };
    int i;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (i = 0; i < beats.size(); i++) send_byte(beats[i][7:0], beats[i][8]);
    drain_text_out();
  endtask

  // Each code point that fold_cp_at gives, once, in random order
  task automatic test_fold_table();
    int order[NUM_FOLD_CPS];
    int i;
    int j;
    int t;
    logic [20:0] cp;
    send_idle_pct = 12;
    stall_pct     = 12;
    for (i = 0; i < NUM_FOLD_CPS; i++) order[i] = i;
    for (i = NUM_FOLD_CPS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < NUM_FOLD_CPS; i++) begin
      cp = fold_cp_at(order[i]);
      send_cp(cp, (cp < 21'h800) ? 2 : 3, (cp < 21'h800) ? 2 : 3, 1'b0);
    end
    drain_text_out();
  endtask

  task automatic test_random_mix(input int idle_p, input int stall_p, input int n_items);
    int first;
    int kind;
    int len;
    int k;
    logic [20:0] cp;
    logic [7:0] b;
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    first         = bytes_sent;
    while (bytes_sent - first < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 19) == 0);
      end else if (kind < 60) begin
        // well-formed sequence, table entry or any code point
        if ($urandom_range(0, 1) == 1) begin
          cp  = fold_cp_at($urandom_range(0, NUM_FOLD_CPS - 1));
          len = (cp < 21'h800) ? 2 : 3;
          if ($urandom_range(0, 4) == 0) len = 4;
        end else begin
          cp  = 21'($urandom);
          len = $urandom_range(2, 4);
        end
        send_cp(cp, len, len, $urandom_range(0, 9) == 0);
      end else if (kind < 75) begin
        // broken: short sequence cut by a non-continuation byte
        len = $urandom_range(2, 4);
        k   = $urandom_range(0, len - 2);
        send_cp(21'($urandom), len, k + 1, 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
        send_byte(b, $urandom_range(0, 9) == 0);
      end else if (kind < 85) begin
        if ($urandom_range(0, 1) == 1) b = 8'($urandom_range(8'h80, 8'hBF));
        else b = 8'($urandom_range(8'hF8, 8'hFF));
        send_byte(b, $urandom_range(0, 9) == 0);
      end else if (kind < 93) begin
        // truncated by end of text
        len = $urandom_range(2, 4);
        k   = $urandom_range(0, len - 2);
        send_cp(21'($urandom), len, k + 1, 1'b1);
      end else begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
      end
    end
    drain_text_out();
  endtask

  // Receiver holds off while bytes keep coming, so the queue fills up
  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = HOLD_CYCLES;
    for (i = 0; i < 12; i++) send_byte(8'($urandom_range(0, 127)), 1'b0);
    send_cp(21'h2026, 3, 3, 1'b0);
    send_cp(21'h2192, 3, 3, 1'b1);
    drain_text_out();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each output beat with the oldest predicted character
  always @(posedge clk) begin
    ascii_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ascii_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected char %h item_last=%b text_last=%b", $realtime,
                   out_char, out_item_last, out_text_last);
      end else begin
        want = ascii_due_q[0];
        ascii_due_q.delete(0);
        if (out_char !== want.ch || out_item_last !== want.item_last ||
            out_text_last !== want.text_last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch char %h/%h item_last %b/%b text_last %b/%b %s",
                     $realtime, want.ch, out_char, want.item_last, out_item_last,
                     want.text_last, out_text_last, "(expected/actual)");
        end
      end
    end
  end

  // Watchdog: cycles in which no beat moves on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout after %0d idle cycles", QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fold_table();
    test_random_mix(0, 0, 10);
    test_random_mix(52, 0, 10);
    test_random_mix(0, 52, 10);
    test_random_mix(12, 12, 10);
    test_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ascii_due_q.size() != 0) begin
      $display("%0d predicted chars never arrived", ascii_due_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- utf8_to_ascii_folder_core.f -----
src/u2a_pkg.sv
src/u2a_front.sv
src/u2a_queue.sv
src/u2a_back.sv
src/utf8_to_ascii_folder_core.sv
dv/tb_top.sv
